// File: design/mvsm_pkg.sv
// ----------------------------------------------------------------------------
// mvsm_pkg
// Shared types and constants of the multi-voice sample mixer.
// ----------------------------------------------------------------------------
package mvsm_pkg;

    localparam int VOICE_SLOTS  = 16;
    localparam int CLIP_ENTRIES = 64;
    localparam int SAMPLE_WORDS = 65536;

    localparam int VW = $clog2(VOICE_SLOTS);
    localparam int CW = $clog2(CLIP_ENTRIES);
    localparam int AW = $clog2(SAMPLE_WORDS);
    localparam int LW = 17;
    localparam int MW = 21;
    localparam logic [LW-1:0] MAX_CLIP_LEN = 17'h10000;

    // command codes
    localparam logic [2:0] FN_LOAD   = 3'd0;
    localparam logic [2:0] FN_DEFINE = 3'd1;
    localparam logic [2:0] FN_START  = 3'd2;
    localparam logic [2:0] FN_MUSIC  = 3'd3;
    localparam logic [2:0] FN_LOW    = 3'd4;
    localparam logic [2:0] FN_CANCEL = 3'd5;
    localparam logic [2:0] FN_CANALL = 3'd6;
    localparam logic [2:0] FN_TICK   = 3'd7;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_FREE = 2'd1;
    localparam logic [1:0] ST_NO_MUS  = 2'd2;
    localparam logic [1:0] ST_LOW_REF = 2'd3;

    // register indexes
    localparam logic [2:0] RG_PAUSED  = 3'd0;
    localparam logic [2:0] RG_MUSIC   = 3'd1;
    localparam logic [2:0] RG_EFFECTS = 3'd2;
    localparam logic [2:0] RG_NOMUSIC = 3'd3;
    localparam logic [2:0] RG_LOWMIN  = 3'd4;

    typedef struct packed {
        logic [2:0]        func;
        logic [AW-1:0]     sample_address;
        logic signed [15:0] sample_value;
        logic [CW-1:0]     clip_id;
        logic [AW-1:0]     clip_start;
        logic [LW-1:0]     clip_length;
        logic [VW-1:0]     slot;
    } t_cmd;

    typedef struct packed {
        logic signed [MW-1:0] mixed_sample;
        logic [VW-1:0]        slot_used;
        logic [1:0]           status;
    } t_res;

endpackage

// File: design/mvsm_cmd_fifo.sv
// ----------------------------------------------------------------------------
// mvsm_cmd_fifo
// Two-entry command queue between the front end and the voice engine.
// ----------------------------------------------------------------------------
module mvsm_cmd_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mvsm_pkg::t_cmd  i_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output mvsm_pkg::t_cmd  o_data
);
    mvsm_pkg::t_cmd r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];

    // advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    // hold payload
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !i_pop) else $error("queue underflow");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("bad count");
`endif
endmodule

// File: design/mvsm_engine.sv
// ----------------------------------------------------------------------------
// mvsm_engine
// Back end: sample memory, clip table, voice state and the per-voice mixer.
// ----------------------------------------------------------------------------
module mvsm_engine (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  mvsm_pkg::t_cmd  i_cmd,
    output logic            o_pop,
    input  logic            i_paused,
    input  logic            i_music_on,
    input  logic            i_effects_on,
    input  logic            i_no_music,
    input  logic [3:0]      i_low_min,
    output logic            o_res_valid,
    input  logic            i_res_ready,
    output mvsm_pkg::t_res  o_res
);
    localparam int VW = mvsm_pkg::VW;
    localparam int AW = mvsm_pkg::AW;
    localparam int CW = mvsm_pkg::CW;
    localparam int LW = mvsm_pkg::LW;
    localparam int MW = mvsm_pkg::MW;
    localparam int NV = mvsm_pkg::VOICE_SLOTS;

    typedef enum logic [2:0] {S_IDLE, S_CLIP, S_MIXA, S_MIXD, S_ADV, S_OUT} t_state;

    // memories
    logic [15:0]   r_smem [mvsm_pkg::SAMPLE_WORDS];
    logic [AW-1:0] r_cbase [mvsm_pkg::CLIP_ENTRIES];
    logic [LW-1:0] r_clen  [mvsm_pkg::CLIP_ENTRIES];
    logic [mvsm_pkg::CLIP_ENTRIES-1:0] r_cload;
    logic [15:0]   r_sdata;
    logic [AW-1:0] r_cb_rd;
    logic [LW-1:0] r_cl_rd;

    // voice state (one entry per voice, small register file)
    logic [NV-1:0] r_act;
    logic [LW-1:0] r_pos [NV];
    logic [LW-1:0] r_vlen [NV];
    logic [AW-1:0] r_vbase [NV];

    t_state         r_state;
    logic [VW-1:0]  r_v;
    logic [VW-1:0]  r_tgt;
    logic           r_ok;
    logic           r_cld;
    logic [2:0]     r_fn;
    logic signed [MW+1:0] r_acc;
    mvsm_pkg::t_res r_res;
    logic           r_rv;

    // free-voice search: first free, and Nth free from voice 1
    logic [VW-1:0] w_first, w_nth;
    logic          w_first_ok, w_nth_ok;
    logic [VW:0]   w_cnt;
    logic [3:0]    w_need;
    always_comb begin
        w_need     = (i_low_min == 4'd0) ? 4'd1 : i_low_min;
        w_first    = '0;
        w_first_ok = 1'b0;
        w_nth      = '0;
        w_nth_ok   = 1'b0;
        w_cnt      = '0;
        for (int k = 1; k < NV; k++) begin
            if (!r_act[k]) begin
                if (!w_first_ok) begin
                    w_first    = VW'(k);
                    w_first_ok = 1'b1;
                end
                w_cnt = w_cnt + 1'b1;
                if (!w_nth_ok && (w_cnt >= (VW+1)'(w_need))) begin
                    w_nth    = VW'(k);
                    w_nth_ok = 1'b1;
                end
            end
        end
    end

    logic w_live;
    logic signed [MW+1:0] w_term;
    assign w_live = r_act[r_v] && (r_pos[r_v] < r_vlen[r_v]);
    always_comb begin
        w_term = '0;
        if (w_live) begin
            if (r_v == '0) begin
                if (i_music_on) w_term = (MW+2)'(signed'(r_sdata)) <<< 1;
            end else if (i_effects_on) begin
                w_term = (MW+2)'(signed'(r_sdata));
            end
        end
    end

    logic [LW-1:0] w_pos1;
    assign w_pos1 = r_pos[r_v] + 1'b1;

    assign o_pop       = (r_state == S_IDLE) && i_valid && !r_rv;
    assign o_res_valid = r_rv;
    assign o_res       = r_res;

    // memory ports
    always_ff @(posedge i_clk) begin
        if (o_pop && i_cmd.func == mvsm_pkg::FN_LOAD)
            r_smem[i_cmd.sample_address] <= i_cmd.sample_value;
        r_sdata <= r_smem[AW'(r_vbase[r_v] + r_pos[r_v][AW-1:0])];
        if (o_pop && i_cmd.func == mvsm_pkg::FN_DEFINE) begin
            r_cbase[i_cmd.clip_id] <= i_cmd.clip_start;
            r_clen[i_cmd.clip_id]  <= (i_cmd.clip_length > mvsm_pkg::MAX_CLIP_LEN)
                                      ? mvsm_pkg::MAX_CLIP_LEN : i_cmd.clip_length;
        end
        r_cb_rd <= r_cbase[i_cmd.clip_id];
        r_cl_rd <= r_clen[i_cmd.clip_id];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rv    <= 1'b0;
            r_act   <= '0;
            r_cload <= '0;
            r_v     <= '0;
            for (int k = 0; k < NV; k++) begin
                r_pos[k]   <= '0;
                r_vlen[k]  <= '0;
                r_vbase[k] <= '0;
            end
        end else begin
            if (r_rv && i_res_ready) r_rv <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_res <= '0;
                        r_acc <= '0;
                        r_v   <= '0;
                        case (i_cmd.func)
                            mvsm_pkg::FN_LOAD: r_rv <= 1'b1;
                            mvsm_pkg::FN_DEFINE: begin
                                r_cload[i_cmd.clip_id] <= 1'b1;
                                r_rv <= 1'b1;
                            end
                            mvsm_pkg::FN_START: begin
                                r_cld <= r_cload[i_cmd.clip_id];
                                r_tgt <= w_first;
                                r_ok  <= w_first_ok;
                                r_state <= S_CLIP;
                            end
                            mvsm_pkg::FN_MUSIC: begin
                                r_cld <= r_cload[i_cmd.clip_id];
                                r_tgt <= '0;
                                r_ok  <= !i_no_music;
                                r_state <= S_CLIP;
                            end
                            mvsm_pkg::FN_LOW: begin
                                r_cld <= r_cload[i_cmd.clip_id];
                                r_tgt <= w_nth;
                                r_ok  <= w_nth_ok;
                                r_state <= S_CLIP;
                            end
                            mvsm_pkg::FN_CANCEL: begin
                                r_act[i_cmd.slot] <= 1'b0;
                                r_rv <= 1'b1;
                            end
                            mvsm_pkg::FN_CANALL: begin
                                r_act <= '0;
                                r_rv  <= 1'b1;
                            end
                            default: begin
                                if (i_paused) r_rv <= 1'b1;
                                else r_state <= S_MIXA;
                            end
                        endcase
                    end
                end
                S_CLIP: begin
                    // occupy voice with clip table entry read last cycle, or set the refusal status
                    if (r_ok) begin
                        r_act[r_tgt]   <= 1'b1;
                        r_pos[r_tgt]   <= '0;
                        r_vbase[r_tgt] <= r_cld ? r_cb_rd : '0;
                        r_vlen[r_tgt]  <= r_cld ? r_cl_rd : '0;
                        r_res.slot_used <= r_tgt;
                    end else begin
                        r_res.status <= (r_fn == mvsm_pkg::FN_MUSIC) ? mvsm_pkg::ST_NO_MUS :
                            (r_fn == mvsm_pkg::FN_LOW) ? mvsm_pkg::ST_LOW_REF :
                            mvsm_pkg::ST_NO_FREE;
                    end
                    r_state <= S_OUT;
                end
                S_MIXA: r_state <= S_MIXD;   // sample read in flight
                S_MIXD: begin
                    r_acc <= r_acc + w_term;
                    r_state <= S_ADV;
                end
                S_ADV: begin
                    // advance or retire this voice
                    if (r_act[r_v]) begin
                        if (!w_live || w_pos1 >= r_vlen[r_v]) r_act[r_v] <= 1'b0;
                        if (w_live) r_pos[r_v] <= w_pos1;
                    end
                    if (r_v == VW'(NV-1)) begin
                        r_res.mixed_sample <= (r_acc > (MW+2)'(1048575)) ? MW'(1048575) :
                            (r_acc < -(MW+2)'(1048576)) ? MW'(-1048576) : MW'(r_acc);
                        r_rv <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_v <= r_v + 1'b1;
                        r_state <= S_MIXA;
                    end
                end
                S_OUT: begin
                    r_rv <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // remember the command kind so a refused start reports its own status
    always_ff @(posedge i_clk) begin
        if (o_pop) r_fn <= i_cmd.func;
    end

`ifndef SYNTHESIS
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == S_IDLE)) else $error("pop while busy");
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rv && !i_res_ready) |=> $stable(r_res)) else $error("result changed");
    a_busy_no_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MIXD) |-> !o_pop) else $error("mix overlap");
`endif
endmodule

// File: design/multi_voice_sample_mixer_core.sv
// A load, define, cancel or paused tick answers straight from idle; a start first reads
// the clip table and fills a voice; a running tick visits every voice in turn, with one
// registered sample-memory read and one accumulate per voice.
// One command is worked at a time; the next leaves the 2-entry queue only after the
// result beat is taken. Reset (synchronous, active low) clears voices, clip valid bits
// and registers; sample memory and clip bases are undefined until written.
// ----------------------------------------------------------------------------
// multi_voice_sample_mixer_core
// Polyphonic sample player with command front end, queue and voice engine.
// ----------------------------------------------------------------------------
module multi_voice_sample_mixer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // func, sample_address, sample_value, clip_id, clip_start, clip_length, slot
    input  logic [79:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // mixed_sample, slot_used, status
    output logic [31:0] m_axis_tdata,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [3:0]  i_cfg_data
);
    logic r_paused, r_music, r_eff, r_nomus;
    logic [3:0] r_lowmin;

    // hold configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_paused <= 1'b0; r_music <= 1'b1; r_eff <= 1'b1;
            r_nomus  <= 1'b0; r_lowmin <= 4'd5;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mvsm_pkg::RG_PAUSED:  r_paused <= i_cfg_data[0];
                mvsm_pkg::RG_MUSIC:   r_music  <= i_cfg_data[0];
                mvsm_pkg::RG_EFFECTS: r_eff    <= i_cfg_data[0];
                mvsm_pkg::RG_NOMUSIC: r_nomus  <= i_cfg_data[0];
                mvsm_pkg::RG_LOWMIN:  r_lowmin <= i_cfg_data;
                default: ;
            endcase
        end
    end

    mvsm_pkg::t_cmd w_in, w_q;
    assign w_in.func           = s_axis_tdata[2:0];
    assign w_in.sample_address = s_axis_tdata[18:3];
    assign w_in.sample_value   = s_axis_tdata[34:19];
    assign w_in.clip_id        = s_axis_tdata[40:35];
    assign w_in.clip_start     = s_axis_tdata[56:41];
    assign w_in.clip_length    = s_axis_tdata[73:57];
    assign w_in.slot           = s_axis_tdata[77:74];

    logic w_full, w_qv, w_pop;
    assign s_axis_tready = !w_full;

    mvsm_cmd_fifo u_fifo (
        .i_clk, .i_rst_n,
        .i_push (s_axis_tvalid && !w_full), .i_data (w_in), .o_full (w_full),
        .i_pop (w_pop), .o_valid (w_qv), .o_data (w_q)
    );

    mvsm_pkg::t_res w_res;
    mvsm_engine u_eng (
        .i_clk, .i_rst_n,
        .i_valid (w_qv), .i_cmd (w_q), .o_pop (w_pop),
        .i_paused (r_paused), .i_music_on (r_music), .i_effects_on (r_eff),
        .i_no_music (r_nomus), .i_low_min (r_lowmin),
        .o_res_valid (m_axis_tvalid), .i_res_ready (m_axis_tready), .o_res (w_res)
    );

    assign m_axis_tdata = {5'd0, w_res.status, w_res.slot_used, w_res.mixed_sample};
endmodule
